/* rtl/tgf_pkg.sv */
// ============================================================================
// tgf_pkg : shared types and constants of the trace gap filler
// Sequencer states, trace phase and register codes.
// ============================================================================
package tgf_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RDJ,
      ST_WIN1,
      ST_WIN2,
      ST_SUM,
      ST_CHECK,
      ST_DIV,
      ST_WB,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_LOADING,
      PH_DRAINING
   } phase_type;

   localparam logic       CMD_LOAD        = 1'b0;
   localparam logic       KIND_STATUS     = 1'b0;
   localparam logic       KIND_SAMPLE     = 1'b1;
   localparam int         CSR_ADDR_W      = 3;
   localparam logic [2:0] ADDR_HOLE_LIMIT = 3'd0;
   localparam logic [6:0] HOLE_LIMIT_RST  = 7'd10;
   localparam logic [6:0] HUNDRED         = 7'd100;
   localparam logic [2:0] SH_START        = 3'd4;
   localparam int         HOLE_OUT_W      = 17;
   localparam int         VALUE_OUT_W     = 32;

endpackage

/* rtl/trace_gap_filler.sv */
// ============================================================================
// trace_gap_filler : hole filling trace buffer
// Loads a trace of samples, checks the hole share, then drains it with
// each hole replaced by a windowed mean of the usable samples.
// ============================================================================
// Load beat: the sample is written in EXEC; the beat that ends the trace also
//   returns a status beat through OUT, and a rejected trace is dropped.
// Drain beat, present sample: read in RDJ and returned through OUT.
// Drain beat, hole: windows of count/16, /8, /4, /2 and /1 samples are tried
//   in turn, each summed through WIN1, WIN2 and SUM; the first that holds data
//   is divided for its mean, written back by WB before OUT; with none, zero.
// The single memory port sets the window sum rate, one sample per cycle.
// Reset: synchronous; empty trace, loading phase, hole limit 10 percent.
module trace_gap_filler #(
   parameter int DEPTH       = 65536,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_cmd,
   input  logic signed [31:0]                   req_sample_value,
   input  logic                                 req_sample_present,
   input  logic                                 req_last_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_result_kind,
   output logic signed [tgf_pkg::VALUE_OUT_W-1:0] rsp_out_value,
   output logic                                 rsp_was_filled,
   output logic                                 rsp_rejected,
   output logic [tgf_pkg::HOLE_OUT_W-1:0]       rsp_hole_count,
   output logic                                 rsp_last_out,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tgf_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import tgf_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = SAMPLE_BITS + CW;
   localparam int MW = CW + 7;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 holes_ff, holes_in;
   logic [CW-1:0]                 didx_ff, didx_in;
   logic [6:0]                    lim_ff;
   logic                          cmd_ff;
   logic signed [SAMPLE_BITS-1:0] val_ff;
   logic                          pres_ff, last_ff;
   logic [2:0]                    sh_ff, sh_in;
   logic [CW-1:0]                 first_ff, first_in;
   logic [CW-1:0]                 nwin_ff, nwin_in;
   logic [CW-1:0]                 k_ff, k_in;
   logic [CW-1:0]                 rem_ff, rem_in;
   logic signed [SW-1:0]          sum_ff, sum_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          rdv_ff, rdv_in;
   logic signed [SAMPLE_BITS-1:0] fill_ff, fill_in;

   logic                          res_kind_ff, res_kind_in;
   logic signed [SAMPLE_BITS-1:0] res_val_ff, res_val_in;
   logic                          res_fill_ff, res_fill_in;
   logic                          res_rej_ff, res_rej_in;
   logic [CW-1:0]                 res_hole_ff, res_hole_in;
   logic                          res_last_ff, res_last_in;

   logic                          rsp_valid_ff;
   logic                          rsp_kind_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_val_ff;
   logic                          rsp_fill_ff, rsp_rej_ff, rsp_last_ff;
   logic [CW-1:0]                 rsp_hole_ff;

   logic                          mem_we;
   logic [AW-1:0]                 mem_addr;
   logic [SAMPLE_BITS:0]          mem_wdata, mem_rdata;
   logic                          div_start, div_done;
   logic signed [SAMPLE_BITS-1:0] div_q;

   logic [CW-1:0]                 cnt_new, holes_new;
   logic [MW-1:0]                 hole_pct, lim_cnt;
   logic                          load_end, rej;
   logic signed [CW+1:0]          f0, lw, fw;
   logic                          out_take, csr_wr;

   tgf_store #(.DEPTH(DEPTH), .WIDTH(SAMPLE_BITS + 1)) u_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   tgf_div #(.NUM_W(SW), .DEN_W(CW), .Q_W(SAMPLE_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign out_take  = !rsp_valid_ff || rsp_ready;
   assign cnt_new   = count_ff + 1'b1;
   assign holes_new = holes_ff + CW'(!pres_ff);
   assign load_end  = last_ff || (cnt_new == CW'(DEPTH));
   assign hole_pct  = MW'(holes_new) * MW'(HUNDRED);
   assign lim_cnt   = MW'(lim_ff) * MW'(cnt_new);
   assign rej       = hole_pct > lim_cnt;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_EXEC;
         ST_EXEC: begin
            state_in = ST_IDLE;
            if (cmd_ff == CMD_LOAD) begin
               if (phase_ff == PH_LOADING && count_ff < CW'(DEPTH) && load_end) begin
                  state_in = ST_OUT;
               end
            end else if (phase_ff == PH_DRAINING && didx_ff < count_ff) begin
               state_in = ST_RDJ;
            end
         end
         ST_RDJ:   state_in = mem_rdata[SAMPLE_BITS] ? ST_OUT : ST_WIN1;
         ST_WIN1:  state_in = ST_WIN2;
         ST_WIN2:  state_in = ST_SUM;
         ST_SUM:   if (rem_ff == '0 && !rdv_ff) state_in = ST_CHECK;
         ST_CHECK: begin
            if (cnt_ff != '0) state_in = ST_DIV;
            else if (sh_ff == '0) state_in = ST_WB;
            else state_in = ST_WIN1;
         end
         ST_DIV:   if (div_done) state_in = ST_WB;
         ST_WB:    state_in = ST_OUT;
         ST_OUT:   if (out_take) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs of the sequencer
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      holes_in    = holes_ff;
      didx_in     = didx_ff;
      sh_in       = sh_ff;
      first_in    = first_ff;
      nwin_in     = nwin_ff;
      k_in        = k_ff;
      rem_in      = rem_ff;
      sum_in      = sum_ff;
      cnt_in      = cnt_ff;
      rdv_in      = 1'b0;
      fill_in     = fill_ff;
      res_kind_in = res_kind_ff;
      res_val_in  = res_val_ff;
      res_fill_in = res_fill_ff;
      res_rej_in  = res_rej_ff;
      res_hole_in = res_hole_ff;
      res_last_in = res_last_ff;
      mem_we      = 1'b0;
      mem_addr    = didx_ff[AW-1:0];
      mem_wdata   = {pres_ff, val_ff};
      div_start   = 1'b0;
      f0          = '0;
      lw          = '0;
      fw          = '0;
      case (state_ff)
         ST_EXEC: begin
            if (cmd_ff == CMD_LOAD) begin
               if (phase_ff == PH_LOADING && count_ff < CW'(DEPTH)) begin
                  mem_we    = 1'b1;
                  mem_addr  = count_ff[AW-1:0];
                  count_in  = cnt_new;
                  holes_in  = holes_new;
                  if (load_end) begin
                     res_kind_in = KIND_STATUS;
                     res_val_in  = '0;
                     res_fill_in = 1'b0;
                     res_rej_in  = rej;
                     res_hole_in = holes_new;
                     res_last_in = 1'b0;
                     didx_in     = '0;
                     if (rej) begin
                        count_in = '0;
                        holes_in = '0;
                        phase_in = PH_LOADING;
                     end else begin
                        phase_in = PH_DRAINING;
                     end
                  end
               end
            end else if (phase_ff == PH_DRAINING && !(didx_ff < count_ff)) begin
               phase_in = PH_LOADING;
               count_in = '0;
               holes_in = '0;
               didx_in  = '0;
            end
         end
         ST_RDJ: begin
            sh_in = SH_START;
            if (mem_rdata[SAMPLE_BITS]) begin
               res_val_in  = mem_rdata[SAMPLE_BITS-1:0];
               res_fill_in = 1'b0;
            end
         end
         ST_WIN1: begin
            nwin_in = count_ff >> sh_ff;
            f0 = (CW+2)'(didx_ff) - (CW+2)'(nwin_in >> 1);
            first_in = (f0 < 0) ? '0 : f0[CW-1:0];
         end
         ST_WIN2: begin
            lw = (CW+2)'(first_ff) + (CW+2)'(nwin_ff) - (CW+2)'(1);
            if (lw > (CW+2)'(count_ff) - (CW+2)'(1)) lw = (CW+2)'(count_ff) - (CW+2)'(1);
            fw = lw - (CW+2)'(nwin_ff) + (CW+2)'(1);
            k_in   = fw[CW-1:0];
            rem_in = nwin_ff;
            sum_in = '0;
            cnt_in = '0;
         end
         ST_SUM: begin
            mem_addr = k_ff[AW-1:0];
            if (rem_ff != '0) begin
               rdv_in = 1'b1;
               k_in   = k_ff + 1'b1;
               rem_in = rem_ff - 1'b1;
            end
            if (rdv_ff && mem_rdata[SAMPLE_BITS]) begin
               sum_in = sum_ff + SW'(signed'(mem_rdata[SAMPLE_BITS-1:0]));
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            if (cnt_ff != '0) begin
               div_start = 1'b1;
            end else if (sh_ff == '0) begin
               fill_in = '0;
            end else begin
               sh_in = sh_ff - 1'b1;
            end
         end
         ST_DIV: if (div_done) fill_in = div_q;
         ST_WB: begin
            mem_we      = 1'b1;
            mem_wdata   = {1'b1, fill_ff};
            res_val_in  = fill_ff;
            res_fill_in = 1'b1;
         end
         default: ;
      endcase

      // close a drain beat: set the result fields of the sample for OUT
      if ((state_ff == ST_RDJ && mem_rdata[SAMPLE_BITS]) || state_ff == ST_WB) begin
         res_kind_in = KIND_SAMPLE;
         res_rej_in  = 1'b0;
         res_hole_in = holes_ff;
         res_last_in = (didx_ff + 1'b1 == count_ff);
         didx_in     = didx_ff + 1'b1;
         if (didx_ff + 1'b1 == count_ff) begin
            phase_in = PH_LOADING;
            count_in = '0;
            holes_in = '0;
            didx_in  = '0;
         end
      end
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LOADING;
         count_ff     <= '0;
         holes_ff     <= '0;
         didx_ff      <= '0;
         lim_ff       <= HOLE_LIMIT_RST;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         holes_ff <= holes_in;
         didx_ff  <= didx_in;
         rdv_ff   <= rdv_in;
         if (csr_wr && csr_paddr == ADDR_HOLE_LIMIT) begin
            lim_ff <= csr_pwdata[6:0];
         end
         if (state_ff == ST_OUT && out_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         cmd_ff  <= req_cmd;
         val_ff  <= req_sample_value[SAMPLE_BITS-1:0];
         pres_ff <= req_sample_present;
         last_ff <= req_last_sample;
      end
      sh_ff       <= sh_in;
      first_ff    <= first_in;
      nwin_ff     <= nwin_in;
      k_ff        <= k_in;
      rem_ff      <= rem_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      fill_ff     <= fill_in;
      res_kind_ff <= res_kind_in;
      res_val_ff  <= res_val_in;
      res_fill_ff <= res_fill_in;
      res_rej_ff  <= res_rej_in;
      res_hole_ff <= res_hole_in;
      res_last_ff <= res_last_in;
      if (state_ff == ST_OUT && out_take) begin
         rsp_kind_ff <= res_kind_ff;
         rsp_val_ff  <= res_val_ff;
         rsp_fill_ff <= res_fill_ff;
         rsp_rej_ff  <= res_rej_ff;
         rsp_hole_ff <= res_hole_ff;
         rsp_last_ff <= res_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_out_value   = VALUE_OUT_W'(rsp_val_ff);
   assign rsp_was_filled  = rsp_fill_ff;
   assign rsp_rejected    = rsp_rej_ff;
   assign rsp_hole_count  = HOLE_OUT_W'(rsp_hole_ff);
   assign rsp_last_out    = rsp_last_ff;
   assign csr_pready      = 1'b1;
   assign csr_prdata      = (csr_paddr == ADDR_HOLE_LIMIT) ? 32'(lim_ff) : '0;
endmodule

/* rtl/tgf_store.sv */
// ============================================================================
// tgf_store : trace sample memory
// One access per cycle (a write also returns the old word), registered read data.
// ============================================================================
module tgf_store #(
   parameter int DEPTH = 65536,
   parameter int WIDTH = 33
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/tgf_div.sv */
// ============================================================================
// tgf_div : iterative signed by unsigned divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ============================================================================
module tgf_div #(
   parameter int NUM_W = 49,
   parameter int DEN_W = 17,
   parameter int Q_W   = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0]        divisor,
   output logic                    done,
   output logic signed [Q_W-1:0]   quotient
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] mag_ff, mag_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic [NUM_W-1:0] q_full;

   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[DEN_W-1:0], mag_ff[NUM_W-1]};
      if (start) begin
         neg_in  = dividend[NUM_W-1];
         mag_in  = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract where it fits
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            mag_in = {mag_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            mag_in = {mag_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign q_full   = neg_ff ? -mag_ff : mag_ff;
   assign quotient = Q_W'(q_full);
   assign done     = done_ff;
endmodule

/* rtl/tgf_checker.sv */
// ============================================================================
// tgf_checker : port level checks of the trace gap filler
// Watches the request and result channels; bound to the top level.
// ============================================================================
module tgf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_kind,
   input logic [31:0] rsp_out_value,
   input logic        rsp_was_filled,
   input logic        rsp_rejected,
   input logic [16:0] rsp_hole_count,
   input logic        rsp_last_out
);
   import tgf_pkg::*;

   // a stalled result beat holds its value, kind and hole count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value)
         && $stable(rsp_result_kind) && $stable(rsp_hole_count))
      else $error("result beat changed while stalled");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_STATUS |->
         rsp_out_value == '0 && !rsp_was_filled && !rsp_last_out)
      else $error("status beat carries sample fields");

   a_sample_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_SAMPLE |-> !rsp_rejected)
      else $error("sample beat flagged rejected");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous beat in work");
endmodule

bind trace_gap_filler tgf_checker u_tgf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_kind (rsp_result_kind),
   .rsp_out_value   (rsp_out_value),
   .rsp_was_filled  (rsp_was_filled),
   .rsp_rejected    (rsp_rejected),
   .rsp_hole_count  (rsp_hole_count),
   .rsp_last_out    (rsp_last_out)
);
